// ===== hdl/cdadd_pkg.sv =====
// ----------------------------------------------------------------------------
// cdadd_pkg
// types, constants and the month length table shared by the date adder
// ----------------------------------------------------------------------------
package cdadd_pkg;

    // low bits of the amount field that take part in an add
    localparam int AMOUNT_BITS = 16;
    localparam int AMT_USED    = (AMOUNT_BITS < 16) ? AMOUNT_BITS : 16;
    localparam logic [15:0] AMT_MASK = 16'((32'd1 << AMT_USED) - 32'd1);

    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [13:0] YEAR_RST   = 14'd2022;
    localparam logic [3:0]  MONTH_RST  = 4'd6;
    localparam logic [4:0]  DAY_RST    = 5'd3;
    localparam logic [3:0]  MONTHS     = 4'd12;
    localparam logic [17:0] DAYS_400Y  = 18'd146097;
    localparam logic [17:0] MOD_BASE   = 18'd400;
    localparam logic [17:0] DIV_BASE   = 18'd12;
    // two steps each: quotient by reciprocal multiply, then remainder
    localparam logic [3:0]  MOD_TOP    = 4'd1;
    localparam logic [3:0]  DIV_TOP    = 4'd1;

    // reciprocals, rounded up, exact over the year and month count ranges
    localparam logic [15:0] MOD_RECIP  = 16'd5243;     // 2^21 / 400
    localparam int          MOD_SHIFT  = 21;
    localparam logic [15:0] DIV_RECIP  = 16'd43691;    // 2^19 / 12
    localparam int          DIV_SHIFT  = 19;

    // commands
    localparam logic [1:0] CMD_SET    = 2'd0;
    localparam logic [1:0] CMD_DAYS   = 2'd1;
    localparam logic [1:0] CMD_MONTHS = 2'd2;
    localparam logic [1:0] CMD_YEARS  = 2'd3;

    // datapath operations
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_LOAD = 3'd1;
    localparam logic [2:0] OP_MOD  = 3'd2;
    localparam logic [2:0] OP_Y400 = 3'd3;
    localparam logic [2:0] OP_WALK = 3'd4;
    localparam logic [2:0] OP_DIV  = 3'd5;
    localparam logic [2:0] OP_FIN  = 3'd6;
    localparam logic [2:0] OP_END  = 3'd7;

    // subtractor operand selection
    localparam logic [1:0] SEL_MOD  = 2'd0;
    localparam logic [1:0] SEL_Y400 = 2'd1;
    localparam logic [1:0] SEL_WALK = 2'd2;
    localparam logic [1:0] SEL_DIV  = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [13:0] set_year;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
        logic [15:0] amount;
    } req_t;

    typedef struct packed {
        logic [13:0] cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic        overflow;
    } res_t;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] sel;
        logic [3:0] k;
    } ctrl_t;

    typedef struct packed {
        logic y_ok;
        logic step_go;
    } stat_t;

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== hdl/cdadd_seq.sv =====
// ----------------------------------------------------------------------------
// cdadd_seq
// sequencer that steps the shared subtractor through one request
// ----------------------------------------------------------------------------
module cdadd_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          cmd,
    input  cdadd_pkg::stat_t    stat,
    output cdadd_pkg::ctrl_t    ctrl,
    output logic                busy,
    output logic                done
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_Y400 = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_END  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [3:0] k_reg, k_next;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        ctrl.op    = cdadd_pkg::OP_NONE;
        ctrl.sel   = cdadd_pkg::SEL_WALK;
        ctrl.k     = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.op = cdadd_pkg::OP_LOAD;
                    case (cmd)
                        cdadd_pkg::CMD_DAYS:
                        begin
                            state_next = S_MOD;
                            k_next     = cdadd_pkg::MOD_TOP;
                        end
                        cdadd_pkg::CMD_MONTHS:
                        begin
                            state_next = S_DIV;
                            k_next     = cdadd_pkg::DIV_TOP;
                        end
                        default: state_next = S_END;
                    endcase
                end
            end
            S_MOD:
            begin
                ctrl.op  = cdadd_pkg::OP_MOD;
                ctrl.sel = cdadd_pkg::SEL_MOD;
                if (k_reg == 4'd0)
                    state_next = S_Y400;
                else
                    k_next = k_reg - 4'd1;
            end
            S_Y400:
            begin
                ctrl.sel = cdadd_pkg::SEL_Y400;
                if (stat.step_go)
                    ctrl.op = cdadd_pkg::OP_Y400;
                else
                    state_next = S_WALK;
            end
            S_WALK:
            begin
                ctrl.sel = cdadd_pkg::SEL_WALK;
                if (stat.step_go)
                    ctrl.op = cdadd_pkg::OP_WALK;
                else
                    state_next = S_END;
            end
            S_DIV:
            begin
                ctrl.op  = cdadd_pkg::OP_DIV;
                ctrl.sel = cdadd_pkg::SEL_DIV;
                if (k_reg == 4'd0)
                    state_next = S_FIN;
                else
                    k_next = k_reg - 4'd1;
            end
            S_FIN:
            begin
                ctrl.op    = cdadd_pkg::OP_FIN;
                state_next = S_END;
            end
            S_END:
            begin
                ctrl.op    = cdadd_pkg::OP_END;
                state_next = S_OUT;
            end
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

endmodule

// ===== hdl/cdadd_dpath.sv =====
// ----------------------------------------------------------------------------
// cdadd_dpath
// date registers, working registers, the shared subtractor and the
// reciprocal multiplier that gives quotients by 400 and by 12
// ----------------------------------------------------------------------------
module cdadd_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  cdadd_pkg::req_t     req,
    input  cdadd_pkg::ctrl_t    ctrl,
    output cdadd_pkg::stat_t    stat,
    output cdadd_pkg::res_t     res
);

    // committed date
    logic [13:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic        ovf_reg, ovf_next;

    // working copies
    logic [16:0] y_reg, y_next;
    logic [3:0]  m_reg, m_next;
    logic [17:0] d_reg, d_next;
    logic [13:0] r_reg, r_next;     // year mod 400
    logic [16:0] t_reg, t_next;     // month count under division
    logic [12:0] q_reg, q_next;     // quotient from the reciprocal multiply

    logic [17:0] sub_a, sub_b;
    logic [18:0] diff;
    logic        ge, gt, leap;
    logic [15:0] amt;
    logic [13:0] yr_clamp;
    logic [3:0]  mo_clamp;
    logic [16:0] mul_a;
    logic [15:0] mul_c;
    logic [32:0] prod;
    logic [12:0] quo;

    assign amt  = req.amount & cdadd_pkg::AMT_MASK;
    assign leap = (r_reg[1:0] == 2'd0)
                  && !(r_reg == 14'd100 || r_reg == 14'd200 || r_reg == 14'd300);

    // quotient estimate, year by 400 or month count by 12
    always_comb
    begin
        if (ctrl.sel == cdadd_pkg::SEL_MOD)
        begin
            mul_a = 17'(r_reg);
            mul_c = cdadd_pkg::MOD_RECIP;
        end
        else
        begin
            mul_a = t_reg;
            mul_c = cdadd_pkg::DIV_RECIP;
        end
    end

    assign prod = 33'(mul_a) * 33'(mul_c);
    assign quo  = (ctrl.sel == cdadd_pkg::SEL_MOD) ? 13'(prod >> cdadd_pkg::MOD_SHIFT)
                                                   : 13'(prod >> cdadd_pkg::DIV_SHIFT);

    // shared subtractor, borrow gives the compare
    always_comb
    begin
        case (ctrl.sel)
            cdadd_pkg::SEL_MOD:
            begin
                sub_a = 18'(r_reg);
                sub_b = 18'(q_reg) * cdadd_pkg::MOD_BASE;
            end
            cdadd_pkg::SEL_Y400:
            begin
                sub_a = d_reg;
                sub_b = cdadd_pkg::DAYS_400Y;
            end
            cdadd_pkg::SEL_DIV:
            begin
                sub_a = 18'(t_reg);
                sub_b = 18'(q_reg) * cdadd_pkg::DIV_BASE;
            end
            default:
            begin
                sub_a = d_reg;
                sub_b = 18'(cdadd_pkg::days_in(m_reg, leap));
            end
        endcase
    end

    assign diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign ge   = !diff[18];
    assign gt   = ge && (diff[17:0] != 18'd0);

    assign stat.y_ok    = (y_reg <= 17'(cdadd_pkg::YEAR_MAX));
    assign stat.step_go = stat.y_ok && gt;

    always_comb
    begin
        if (req.set_year == 14'd0)
            yr_clamp = 14'd1;
        else if (req.set_year > cdadd_pkg::YEAR_MAX)
            yr_clamp = cdadd_pkg::YEAR_MAX;
        else
            yr_clamp = req.set_year;
        if (req.set_month == 4'd0)
            mo_clamp = 4'd1;
        else if (req.set_month > cdadd_pkg::MONTHS)
            mo_clamp = cdadd_pkg::MONTHS;
        else
            mo_clamp = req.set_month;
    end

    always_comb
    begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        ovf_next   = ovf_reg;
        y_next     = y_reg;
        m_next     = m_reg;
        d_next     = d_reg;
        r_next     = r_reg;
        t_next     = t_reg;
        q_next     = q_reg;
        case (ctrl.op)
            cdadd_pkg::OP_LOAD:
            begin
                y_next = 17'(year_reg);
                m_next = month_reg;
                d_next = 18'(day_reg);
                r_next = year_reg;
                t_next = 17'(month_reg - 4'd1) + 17'(amt);
                q_next = 13'd0;
                case (req.cmd)
                    cdadd_pkg::CMD_SET:
                    begin
                        y_next = 17'(yr_clamp);
                        m_next = mo_clamp;
                        d_next = (req.set_day == 5'd0) ? 18'd1 : 18'(req.set_day);
                    end
                    cdadd_pkg::CMD_DAYS:  d_next = 18'(day_reg) + 18'(amt);
                    cdadd_pkg::CMD_YEARS: y_next = 17'(year_reg) + 17'(amt);
                    default:              y_next = 17'(year_reg);
                endcase
            end
            cdadd_pkg::OP_MOD:
            begin
                // first step takes the quotient, second leaves the remainder
                if (ctrl.k != 4'd0)
                    q_next = quo;
                else
                    r_next = diff[13:0];
            end
            cdadd_pkg::OP_Y400:
            begin
                d_next = diff[17:0];
                y_next = y_reg + 17'd400;
            end
            cdadd_pkg::OP_WALK:
            begin
                d_next = diff[17:0];
                if (m_reg == cdadd_pkg::MONTHS)
                begin
                    m_next = 4'd1;
                    y_next = y_reg + 17'd1;
                    r_next = (r_reg == 14'd399) ? 14'd0 : r_reg + 14'd1;
                end
                else
                    m_next = m_reg + 4'd1;
            end
            cdadd_pkg::OP_DIV:
            begin
                if (ctrl.k != 4'd0)
                    q_next = quo;
                else
                    t_next = diff[16:0];
            end
            cdadd_pkg::OP_FIN:
            begin
                y_next = 17'(year_reg) + 17'(q_reg);
                m_next = t_reg[3:0] + 4'd1;
            end
            cdadd_pkg::OP_END:
            begin
                ovf_next = !stat.y_ok;
                if (stat.y_ok)
                begin
                    year_next  = y_reg[13:0];
                    month_next = m_reg;
                    day_next   = d_reg[4:0];
                end
            end
            default: ovf_next = ovf_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg  <= cdadd_pkg::YEAR_RST;
            month_reg <= cdadd_pkg::MONTH_RST;
            day_reg   <= cdadd_pkg::DAY_RST;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
        m_reg <= m_next;
        d_reg <= d_next;
        r_reg <= r_next;
        t_reg <= t_next;
        q_reg <= q_next;
    end

    assign res.cur_year  = year_reg;
    assign res.cur_month = month_reg;
    assign res.cur_day   = day_reg;
    assign res.overflow  = ovf_reg;

endmodule

// ===== hdl/calendar_date_adder.sv =====
// ----------------------------------------------------------------------------
// calendar_date_adder
// gregorian date register with set, add days, add months and add years
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low; busy then stays high
// until the result has been shown. the result (date after the request and the
// overflow flag) is on res while done is high for exactly one cycle, and the
// receiver cannot stall it; res keeps it until the next update. add months
// uses a reciprocal multiply for the quotient by twelve and the shared
// subtractor for the remainder. add days first reduces the year mod 400 for
// the leap rule, then takes off whole 400-year spans, and then the single
// shared subtractor takes off one month length per cycle, so an add of days
// runs longer the more month boundaries it crosses. an update that would
// take the year past 9999
// keeps the old date and sets overflow
// ----------------------------------------------------------------------------
module calendar_date_adder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  cdadd_pkg::req_t     req,
    output logic                done,
    output cdadd_pkg::res_t     res
);

    cdadd_pkg::ctrl_t ctrl;
    cdadd_pkg::stat_t stat;

    // sequencer: picks the subtractor operands and the step for each cycle
    cdadd_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (req.cmd),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy),
        .done  (done)
    );

    // datapath: holds the date and the working copies during a request
    cdadd_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ctrl  (ctrl),
        .stat  (stat),
        .res   (res)
    );

endmodule
